>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CSSTL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csstl assertion failed");

// next-cycle implication
`define CSSTL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csstl assertion failed");

`endif

>>> src/csstl_pkg.sv
// ----------------------------------------------------------------------------
// csstl_pkg
// Types, token kinds, lexer modes and helper functions of the CSS lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package csstl_pkg;

	localparam int LOOKAHEAD_DEF  = 3;
	localparam int MAX_HEX_DIGITS = 6;
	localparam int MAX_RESULTS    = 16;
	localparam int RBUF           = 8;

	localparam logic [23:0] CP_MAX  = 24'h10FFFF;
	localparam logic [23:0] SURR_LO = 24'h00D800;
	localparam logic [23:0] SURR_HI = 24'h00DFFF;
	localparam logic [7:0]  RPL_B0  = 8'hEF;
	localparam logic [7:0]  RPL_B1  = 8'hBF;
	localparam logic [7:0]  RPL_B2  = 8'hBD;

	localparam logic [4:0] K_WS       = 5'd0;
	localparam logic [4:0] K_STRING   = 5'd1;
	localparam logic [4:0] K_HASH     = 5'd2;
	localparam logic [4:0] K_AT       = 5'd3;
	localparam logic [4:0] K_NUMBER   = 5'd4;
	localparam logic [4:0] K_PERCENT  = 5'd5;
	localparam logic [4:0] K_DIM      = 5'd6;
	localparam logic [4:0] K_IDENT    = 5'd7;
	localparam logic [4:0] K_FUNC     = 5'd8;
	localparam logic [4:0] K_URL      = 5'd9;
	localparam logic [4:0] K_DELIM    = 5'd10;
	localparam logic [4:0] K_COLON    = 5'd11;
	localparam logic [4:0] K_SEMI     = 5'd12;
	localparam logic [4:0] K_COMMA    = 5'd13;
	localparam logic [4:0] K_LBRACE   = 5'd14;
	localparam logic [4:0] K_RBRACE   = 5'd15;
	localparam logic [4:0] K_LPAREN   = 5'd16;
	localparam logic [4:0] K_RPAREN   = 5'd17;
	localparam logic [4:0] K_LBRACKET = 5'd18;
	localparam logic [4:0] K_RBRACKET = 5'd19;
	localparam logic [4:0] K_EOF      = 5'd20;

	typedef enum logic [15:0] {
		M_IDLE       = 16'h0001,
		M_COMMENT    = 16'h0002,
		M_WS         = 16'h0004,
		M_STRING     = 16'h0008,
		M_NAME       = 16'h0010,
		M_INT        = 16'h0020,
		M_FRAC       = 16'h0040,
		M_EXPMARK    = 16'h0080,
		M_EXPSIGN    = 16'h0100,
		M_EXP        = 16'h0200,
		M_SUFFIX     = 16'h0400,
		M_URL_LEAD   = 16'h0800,
		M_URL_QUOTED = 16'h1000,
		M_URL_RAW    = 16'h2000,
		M_URL_TAIL   = 16'h4000,
		M_HEX        = 16'h8000
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [4:0] token_kind;
		logic [7:0] out_byte;
		logic       has_byte;
		logic       text_part;
		logic       token_end;
		logic       last_result;
	} out_item_t;

	typedef struct packed {
		logic [4:0] token_kind;
		logic [7:0] out_byte;
		logic       has_byte;
		logic       text_part;
		logic       token_end;
	} res_t;

	typedef struct packed {
		res_t res;
		logic flush;
	} ev_t;

	typedef struct packed {
		logic [2:0]      n;
		logic [3:0][7:0] b;
	} utf8_t;

	function automatic res_t mk_res(input logic [4:0] k, input logic [7:0] b,
			input logic h, input logic p, input logic e);
		res_t r;
		r.token_kind = k;
		r.out_byte   = b;
		r.has_byte   = h;
		r.text_part  = p;
		r.token_end  = e;
		return r;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0C;
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic id_start(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c[7];
	endfunction

	function automatic logic name_ch(input logic [7:0] c);
		return id_start(c) || is_dig(c) || c == "-";
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		t = is_dig(c) ? c - "0" : (c | 8'h20) - "a" + 8'd10;
		return t[3:0];
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] url_char(input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0:    r = "u";
			2'd1:    r = "r";
			2'd2:    r = "l";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			":":     k = K_COLON;
			";":     k = K_SEMI;
			",":     k = K_COMMA;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"[":     k = K_LBRACKET;
			"]":     k = K_RBRACKET;
			default: k = K_DELIM;
		endcase
		return k;
	endfunction

	function automatic utf8_t utf8_enc(input logic [23:0] cp);
		utf8_t r;
		r.n = 3'd0;
		r.b = '0;
		if (cp == 24'd0 || (cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX) begin
			r.n = 3'd3;
			r.b[0] = RPL_B0;
			r.b[1] = RPL_B1;
			r.b[2] = RPL_B2;
		end else if (cp <= 24'h7F) begin
			r.n = 3'd1;
			r.b[0] = cp[7:0];
		end else if (cp <= 24'h7FF) begin
			r.n = 3'd2;
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
		end else if (cp <= 24'hFFFF) begin
			r.n = 3'd3;
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
		end else begin
			r.n = 3'd4;
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/css_token_stream_lexer_unit.sv
// ----------------------------------------------------------------------------
// css_token_stream_lexer_unit
// CSS tokenizer: stylesheet bytes in, tagged token text bytes out.
// ----------------------------------------------------------------------------
// channel   direction  payload     handshake
// byte      sink       in_item_t   byte_valid / byte_ready
// tok       source     out_item_t  tok_valid / tok_ready
//
// A plain byte gets one lexer step, then close and load of the next.
// The step sequencer does one tokenizer step a cycle while its result buffer
// is empty; extra results of a step wait there (an escape gives up to seven
// with held ident bytes). End of input flushes the remaining steps, then eof.
// Reset is asynchronous and clears all control state at once; no clearing pass.
// Stalls: two-entry input queue, result buffer, held result, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module css_token_stream_lexer_unit #(
	parameter int LOOKAHEAD = csstl_pkg::LOOKAHEAD_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  csstl_pkg::in_item_t  byte_data,
	output logic                 tok_valid,
	input  logic                 tok_ready,
	output csstl_pkg::out_item_t tok_data
);
	import csstl_pkg::*;

	logic     f_valid, f_pop, ev_valid, ev_ready;
	in_item_t f_data;
	ev_t      ev;

	csstl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.f_valid    (f_valid),
		.f_data     (f_data),
		.f_pop      (f_pop)
	);

	csstl_engine #(
		.LOOKAHEAD (LOOKAHEAD)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.f_valid  (f_valid),
		.f_data   (f_data),
		.f_pop    (f_pop),
		.ev_valid (ev_valid),
		.ev       (ev),
		.ev_ready (ev_ready)
	);

	csstl_outstage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev        (ev),
		.ev_ready  (ev_ready),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

endmodule
`default_nettype wire

>>> src/csstl_front.sv
// ----------------------------------------------------------------------------
// csstl_front
// Two-entry input queue that takes stylesheet bytes from the source.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module csstl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  csstl_pkg::in_item_t byte_data,
	output logic                f_valid,
	output csstl_pkg::in_item_t f_data,
	input  logic                f_pop
);
	import csstl_pkg::*;

	in_item_t   mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign byte_ready = cnt_q != 2'd2;
	assign push       = byte_valid && byte_ready;
	assign f_valid    = cnt_q != 2'd0;
	assign f_data     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (f_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, f_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= byte_data;
	end

endmodule
`default_nettype wire

>>> src/csstl_engine.sv
// ----------------------------------------------------------------------------
// csstl_engine
// Lexer sequencer: one step a cycle on the lookahead window when buffer empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module csstl_engine #(
	parameter int LOOKAHEAD = csstl_pkg::LOOKAHEAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                f_valid,
	input  csstl_pkg::in_item_t f_data,
	output logic                f_pop,
	output logic                ev_valid,
	output csstl_pkg::ev_t      ev,
	input  logic                ev_ready
);
	import csstl_pkg::*;

	localparam int W  = LOOKAHEAD + 1;
	localparam int LW = $clog2(W + 1);
	localparam int BW = $clog2(RBUF);

	logic          active_q, eoi_q, eof_done_q;
	logic [4:0]    cnt_q;
	logic [7:0]    win_q [W];
	logic [LW-1:0] len_q;
	mode_t         mode_q, resume_q;
	logic [23:0]   esc_q;
	logic [2:0]    hexc_q;
	logic [7:0]    quote_q;
	logic [4:0]    kind_q;
	logic          holding_q;
	logic [1:0]    hcnt_q;
	logic [7:0]    hold_q [3];
	res_t          buf_q [RBUF];
	logic [BW-1:0] bcnt_q;

	mode_t         n_mode, n_resume;
	logic [23:0]   n_esc;
	logic [2:0]    n_hexc;
	logic [7:0]    n_quote;
	logic [4:0]    n_kind;
	logic          n_holding;
	logic [1:0]    n_hcnt;
	logic [7:0]    n_hold [3];
	logic [2:0]    tk;
	res_t          rl [RBUF];
	logic [2:0]    ne;
	logic [2:0]    s_cnt;
	logic [3:0][7:0] s_b;
	utf8_t         u;
	logic          eof_step, do_esc, pc_en;
	logic [23:0]   pc_val;
	logic [7:0]    lo;

	logic [7:0] c [4];
	logic       v [4];
	logic       sign0, ws0, dig0, dig1, dig2, sn01;

	logic          buf_empty, done, do_step, ev_acc, flush_acc, load;
	logic [4:0]    room;
	logic [2:0]    nk;
	logic [LW-1:0] len_sh, len_b;
	logic [7:0]    win_sh [W];
	logic [7:0]    win_b [W];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			c[k] = win_q[k];
			v[k] = len_q > LW'(k);
		end
	end

	assign sign0 = v[0] && (c[0] == "+" || c[0] == "-");
	assign ws0   = v[0] && is_ws(c[0]);
	assign dig0  = v[0] && is_dig(c[0]);
	assign dig1  = v[1] && is_dig(c[1]);
	assign dig2  = v[2] && is_dig(c[2]);
	assign sn01  = (v[0] && (id_start(c[0]) || c[0] == "\\")) ||
		(v[0] && c[0] == "-" && v[1] && (id_start(c[1]) || c[1] == "-" || c[1] == "\\"));

	always_comb begin
		n_mode    = mode_q;
		n_resume  = resume_q;
		n_esc     = esc_q;
		n_hexc    = hexc_q;
		n_quote   = quote_q;
		n_kind    = kind_q;
		n_holding = holding_q;
		n_hcnt    = hcnt_q;
		n_hold    = hold_q;
		tk        = 3'd0;
		ne        = 3'd0;
		for (int i = 0; i < RBUF; i++) rl[i] = '0;
		s_cnt     = 3'd0;
		s_b       = '0;
		u         = '0;
		eof_step  = 1'b0;
		do_esc    = 1'b0;
		pc_en     = 1'b0;
		pc_val    = 24'd0;
		lo        = 8'd0;
		if (eoi_q && mode_q == M_IDLE && len_q == '0) begin
			eof_step = 1'b1;
			rl[0] = mk_res(K_EOF, 8'd0, 1'b0, 1'b0, 1'b1);
			ne = 3'd1;
		end else begin
			case (mode_q)
				M_COMMENT: begin
					if (!v[0]) n_mode = M_IDLE;
					else if (c[0] == "*" && v[1] && c[1] == "/") begin
						tk = 3'd2;
						n_mode = M_IDLE;
					end else tk = 3'd1;
				end
				M_WS: begin
					if (ws0) tk = 3'd1;
					else begin
						rl[ne] = mk_res(K_WS, " ", 1'b1, 1'b0, 1'b1);
						ne = ne + 3'd1;
						n_mode = M_IDLE;
					end
				end
				M_STRING: begin
					if (!v[0] || (c[0] == 8'h0A || c[0] == 8'h0D || c[0] == 8'h0C)) begin
						rl[ne] = mk_res(K_STRING, 8'd0, 1'b0, 1'b0, 1'b1);
						ne = ne + 3'd1;
						n_mode = M_IDLE;
					end else if (c[0] == quote_q) begin
						tk = 3'd1;
						rl[ne] = mk_res(K_STRING, 8'd0, 1'b0, 1'b0, 1'b1);
						ne = ne + 3'd1;
						n_mode = M_IDLE;
					end else if (c[0] == "\\") begin
						if (!v[1]) tk = 3'd1;
						else if (c[1] == 8'h0A || c[1] == 8'h0C) tk = 3'd2;
						else if (c[1] == 8'h0D) tk = (v[2] && c[2] == 8'h0A) ? 3'd3 : 3'd2;
						else do_esc = 1'b1;
					end else begin
						tk = 3'd1;
						s_cnt = 3'd1;
						s_b[0] = c[0];
					end
				end
				M_NAME: begin
					if (v[0] && c[0] == "\\" && v[1]) do_esc = 1'b1;
					else if (v[0] && name_ch(c[0])) begin
						tk = 3'd1;
						s_cnt = 3'd1;
						s_b[0] = c[0];
					end else if (kind_q != K_IDENT) begin
						rl[ne] = mk_res(kind_q, 8'd0, 1'b0, 1'b0, 1'b1);
						ne = ne + 3'd1;
						n_mode = M_IDLE;
					end else if (v[0] && c[0] == "(" && holding_q && hcnt_q == 2'd3) begin
						tk = 3'd1;
						n_hcnt = 2'd0;
						n_holding = 1'b0;
						n_kind = K_URL;
						n_mode = M_URL_LEAD;
					end else begin
						if (v[0] && c[0] == "(") tk = 3'd1;
						for (int i = 0; i < 3; i++) begin
							if (2'(i) < hcnt_q) begin
								rl[ne] = mk_res(kind_q, hold_q[i], 1'b1, 1'b0, 1'b0);
								ne = ne + 3'd1;
							end
						end
						n_hcnt = 2'd0;
						rl[ne] = mk_res((v[0] && c[0] == "(") ? K_FUNC : K_IDENT, 8'd0,
							1'b0, 1'b0, 1'b1);
						ne = ne + 3'd1;
						n_mode = M_IDLE;
					end
				end
				M_INT, M_FRAC: begin
					if (dig0) begin
						tk = 3'd1;
						rl[ne] = mk_res(K_NUMBER, c[0], 1'b1, 1'b1, 1'b0);
						ne = ne + 3'd1;
					end else if (mode_q == M_INT && v[0] && c[0] == "." && dig1) begin
						tk = 3'd1;
						rl[ne] = mk_res(K_NUMBER, ".", 1'b1, 1'b1, 1'b0);
						ne = ne + 3'd1;
						n_mode = M_FRAC;
					end else n_mode = M_EXPMARK;
				end
				M_EXPMARK: begin
					if (v[0] && (c[0] == "e" || c[0] == "E") &&
							(dig1 || (v[1] && (c[1] == "+" || c[1] == "-")))) begin
						tk = 3'd1;
						rl[ne] = mk_res(K_NUMBER, c[0], 1'b1, 1'b1, 1'b0);
						ne = ne + 3'd1;
						n_mode = M_EXPSIGN;
					end else n_mode = M_SUFFIX;
				end
				M_EXPSIGN: begin
					if (sign0) begin
						tk = 3'd1;
						rl[ne] = mk_res(K_NUMBER, c[0], 1'b1, 1'b1, 1'b0);
						ne = ne + 3'd1;
					end
					n_mode = M_EXP;
				end
				M_EXP: begin
					if (dig0) begin
						tk = 3'd1;
						rl[ne] = mk_res(K_NUMBER, c[0], 1'b1, 1'b1, 1'b0);
						ne = ne + 3'd1;
					end else n_mode = M_SUFFIX;
				end
				M_SUFFIX: begin
					if (v[0] && c[0] == "%") begin
						tk = 3'd1;
						rl[ne] = mk_res(K_PERCENT, "%", 1'b1, 1'b0, 1'b1);
						ne = ne + 3'd1;
						n_mode = M_IDLE;
					end else if (sn01) begin
						n_kind = K_DIM;
						n_holding = 1'b0;
						n_hcnt = 2'd0;
						n_mode = M_NAME;
					end else begin
						rl[ne] = mk_res(K_NUMBER, 8'd0, 1'b0, 1'b0, 1'b1);
						ne = ne + 3'd1;
						n_mode = M_IDLE;
					end
				end
				M_URL_LEAD: begin
					if (ws0) tk = 3'd1;
					else if (v[0] && (c[0] == "\"" || c[0] == "'")) begin
						tk = 3'd1;
						n_quote = c[0];
						n_mode = M_URL_QUOTED;
					end else n_mode = M_URL_RAW;
				end
				M_URL_QUOTED: begin
					if (!v[0]) n_mode = M_URL_TAIL;
					else if (c[0] == quote_q) begin
						tk = 3'd1;
						n_mode = M_URL_TAIL;
					end else if (c[0] == "\\") do_esc = 1'b1;
					else begin
						tk = 3'd1;
						s_cnt = 3'd1;
						s_b[0] = c[0];
					end
				end
				M_URL_RAW: begin
					if (!v[0] || c[0] == "\"" || c[0] == "'" || c[0] == ")") begin
						if (v[0] && c[0] == ")") tk = 3'd1;
						rl[ne] = mk_res(K_URL, 8'd0, 1'b0, 1'b0, 1'b1);
						ne = ne + 3'd1;
						n_mode = M_IDLE;
					end else if (ws0) n_mode = M_URL_TAIL;
					else if (c[0] == "\\") do_esc = 1'b1;
					else begin
						tk = 3'd1;
						s_cnt = 3'd1;
						s_b[0] = c[0];
					end
				end
				M_URL_TAIL: begin
					if (ws0) tk = 3'd1;
					else begin
						if (v[0] && c[0] == ")") tk = 3'd1;
						rl[ne] = mk_res(K_URL, 8'd0, 1'b0, 1'b0, 1'b1);
						ne = ne + 3'd1;
						n_mode = M_IDLE;
					end
				end
				M_HEX: begin
					if (hexc_q < 3'(MAX_HEX_DIGITS) && v[0] && is_hex(c[0])) begin
						n_esc = {esc_q[19:0], hex_val(c[0])};
						n_hexc = hexc_q + 3'd1;
						tk = 3'd1;
					end else begin
						if (ws0) tk = 3'd1;
						n_mode = resume_q;
						pc_en = 1'b1;
						pc_val = esc_q;
						n_esc = 24'd0;
						n_hexc = 3'd0;
					end
				end
				default: begin
					if (!v[0]) n_mode = M_IDLE;
					else if (c[0] == "/" && v[1] && c[1] == "*") begin
						tk = 3'd2;
						n_mode = M_COMMENT;
					end else if (ws0) begin
						tk = 3'd1;
						n_mode = M_WS;
					end else if (c[0] == "\"" || c[0] == "'") begin
						tk = 3'd1;
						n_quote = c[0];
						n_kind = K_STRING;
						n_holding = 1'b0;
						n_mode = M_STRING;
					end else if (c[0] == "#" || c[0] == "@") begin
						tk = 3'd1;
						if (v[1] && (id_start(c[1]) || c[1] == "\\")) begin
							n_kind = (c[0] == "#") ? K_HASH : K_AT;
							n_holding = 1'b0;
							n_hcnt = 2'd0;
							n_mode = M_NAME;
						end else begin
							rl[ne] = mk_res(K_DELIM, c[0], 1'b1, 1'b0, 1'b1);
							ne = ne + 3'd1;
						end
					end else if (dig0 || (c[0] == "." && dig1) || (sign0 && dig1) ||
							(sign0 && v[1] && c[1] == "." && dig2)) begin
						if (sign0) begin
							tk = 3'd1;
							rl[ne] = mk_res(K_NUMBER, c[0], 1'b1, 1'b1, 1'b0);
							ne = ne + 3'd1;
						end
						n_mode = M_INT;
					end else if (c[0] == "<" && v[1] && c[1] == "!" && v[2] && c[2] == "-" &&
							v[3] && c[3] == "-") begin
						tk = 3'd4;
						rl[ne] = mk_res(K_WS, " ", 1'b1, 1'b0, 1'b1);
						ne = ne + 3'd1;
					end else if (c[0] == "-" && v[1] && c[1] == "-" && v[2] && c[2] == ">") begin
						tk = 3'd3;
						rl[ne] = mk_res(K_WS, " ", 1'b1, 1'b0, 1'b1);
						ne = ne + 3'd1;
					end else if (sn01 && !(c[0] == "\\" && !v[1])) begin
						n_kind = K_IDENT;
						n_holding = 1'b1;
						n_hcnt = 2'd0;
						n_mode = M_NAME;
					end else begin
						tk = 3'd1;
						rl[ne] = mk_res(punct_kind(c[0]), c[0], 1'b1, 1'b0, 1'b1);
						ne = ne + 3'd1;
					end
				end
			endcase

			if (do_esc) begin
				if (!v[1]) begin
					tk = 3'd1;
					pc_en = 1'b1;
					pc_val = 24'd0;
				end else if (is_hex(c[1])) begin
					tk = 3'd1;
					n_esc = 24'd0;
					n_hexc = 3'd0;
					n_resume = mode_q;
					n_mode = M_HEX;
				end else begin
					tk = 3'd2;
					s_cnt = 3'd1;
					s_b[0] = c[1];
				end
			end

			if (pc_en) begin
				u = utf8_enc(pc_val);
				s_cnt = u.n;
				s_b = u.b;
			end

			if (s_cnt != 3'd0) begin
				lo = to_lower(s_b[0]);
				if (holding_q && hcnt_q < 2'd3 && lo == url_char(hcnt_q)) begin
					for (int i = 0; i < 3; i++) begin
						if (hcnt_q == 2'(i)) n_hold[i] = s_b[0];
					end
					n_hcnt = hcnt_q + 2'd1;
				end else begin
					if (holding_q) begin
						for (int i = 0; i < 3; i++) begin
							if (2'(i) < hcnt_q) begin
								rl[ne] = mk_res(kind_q, hold_q[i], 1'b1, 1'b0, 1'b0);
								ne = ne + 3'd1;
							end
						end
						n_hcnt = 2'd0;
						n_holding = 1'b0;
					end
					rl[ne] = mk_res(kind_q, s_b[0], 1'b1, 1'b0, 1'b0);
					ne = ne + 3'd1;
				end
				for (int j = 1; j < 4; j++) begin
					if (3'(j) < s_cnt) begin
						rl[ne] = mk_res(kind_q, s_b[j], 1'b1, 1'b0, 1'b0);
						ne = ne + 3'd1;
					end
				end
			end
		end
	end

	assign room      = 5'(MAX_RESULTS) - cnt_q;
	assign nk        = (5'(ne) > room) ? room[2:0] : ne;
	assign buf_empty = bcnt_q == '0;
	assign done      = eoi_q ? eof_done_q : (len_q <= LW'(LOOKAHEAD));
	assign do_step   = active_q && buf_empty && !done;

	always_comb begin
		ev_valid = 1'b0;
		ev.res   = buf_q[0];
		ev.flush = 1'b0;
		if (!buf_empty) begin
			ev_valid = 1'b1;
		end else if (do_step) begin
			ev_valid = nk != 3'd0;
			ev.res   = rl[0];
		end else if (active_q) begin
			ev_valid = 1'b1;
			ev.flush = 1'b1;
		end
	end

	assign ev_acc    = ev_valid && ev_ready;
	assign flush_acc = active_q && buf_empty && done && ev_ready;
	assign load      = f_valid && (!active_q || flush_acc);
	assign f_pop     = load;

	assign len_sh = (len_q > LW'(tk)) ? len_q - LW'(tk) : '0;

	always_comb begin
		for (int i = 0; i < W; i++) begin
			win_sh[i] = win_q[i];
			for (int k = 0; k < 5; k++) begin
				if (tk == 3'(k) && i + k < W) win_sh[i] = win_q[i + k];
			end
		end
		len_b = (flush_acc && eoi_q) ? '0 : (do_step ? len_sh : len_q);
		for (int i = 0; i < W; i++) begin
			win_b[i] = do_step ? win_sh[i] : win_q[i];
			if (load && LW'(i) == len_b) win_b[i] = f_data.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			eoi_q      <= 1'b0;
			eof_done_q <= 1'b0;
			cnt_q      <= 5'd0;
			len_q      <= '0;
			mode_q     <= M_IDLE;
			resume_q   <= M_IDLE;
			esc_q      <= 24'd0;
			hexc_q     <= 3'd0;
			quote_q    <= 8'd0;
			kind_q     <= K_WS;
			holding_q  <= 1'b0;
			hcnt_q     <= 2'd0;
			bcnt_q     <= '0;
		end else begin
			len_q <= load ? len_b + LW'(1) : len_b;
			if (!buf_empty && ev_acc) bcnt_q <= bcnt_q - BW'(1);
			if (do_step) begin
				mode_q    <= n_mode;
				resume_q  <= n_resume;
				esc_q     <= n_esc;
				hexc_q    <= n_hexc;
				quote_q   <= n_quote;
				kind_q    <= n_kind;
				holding_q <= n_holding;
				hcnt_q    <= n_hcnt;
				cnt_q     <= cnt_q + 5'(nk);
				if (eof_step) eof_done_q <= 1'b1;
				bcnt_q    <= (ev_acc) ? BW'(nk - 3'd1) : BW'(nk);
			end
			if (flush_acc) begin
				active_q <= 1'b0;
				if (eoi_q) begin
					mode_q    <= M_IDLE;
					resume_q  <= M_IDLE;
					esc_q     <= 24'd0;
					hexc_q    <= 3'd0;
					quote_q   <= 8'd0;
					kind_q    <= K_WS;
					holding_q <= 1'b0;
					hcnt_q    <= 2'd0;
				end
			end
			if (load) begin
				active_q   <= 1'b1;
				eoi_q      <= f_data.end_of_input;
				eof_done_q <= 1'b0;
				cnt_q      <= 5'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_b;
		if (do_step) begin
			hold_q <= n_hold;
			for (int i = 0; i < RBUF; i++) begin
				if (ev_acc) buf_q[i] <= (i + 1 < RBUF) ? rl[(i + 1) % RBUF] : rl[i];
				else buf_q[i] <= rl[i];
			end
		end else if (!buf_empty && ev_acc) begin
			for (int i = 0; i + 1 < RBUF; i++) buf_q[i] <= buf_q[i + 1];
		end
	end

endmodule
`default_nettype wire

>>> src/csstl_outstage.sv
// ----------------------------------------------------------------------------
// csstl_outstage
// Holds back one result to mark the last of each byte, then registers it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module csstl_outstage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ev_valid,
	input  csstl_pkg::ev_t       ev,
	output logic                 ev_ready,
	output logic                 tok_valid,
	input  logic                 tok_ready,
	output csstl_pkg::out_item_t tok_data
);
	import csstl_pkg::*;

	logic      pend_v_q, out_v_q;
	res_t      pend_q;
	out_item_t out_q;
	logic      ev_acc, move;

	assign ev_ready  = !pend_v_q || !out_v_q || tok_ready;
	assign ev_acc    = ev_valid && ev_ready;
	assign move      = ev_acc && pend_v_q;
	assign tok_valid = out_v_q;
	assign tok_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && tok_ready) out_v_q <= 1'b0;
			if (move) out_v_q <= 1'b1;
			if (ev_acc) pend_v_q <= !ev.flush;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q.token_kind  <= pend_q.token_kind;
			out_q.out_byte    <= pend_q.out_byte;
			out_q.has_byte    <= pend_q.has_byte;
			out_q.text_part   <= pend_q.text_part;
			out_q.token_end   <= pend_q.token_end;
			out_q.last_result <= ev.flush;
		end
		if (ev_acc && !ev.flush) pend_q <= ev.res;
	end

endmodule
`default_nettype wire

>>> src/csstl_checker.sv
// ----------------------------------------------------------------------------
// csstl_checker
// Port-level checks of the CSS tokenizer result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module csstl_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 byte_valid,
	input wire logic                 byte_ready,
	input wire csstl_pkg::in_item_t  byte_data,
	input wire logic                 tok_valid,
	input wire logic                 tok_ready,
	input wire csstl_pkg::out_item_t tok_data
);
	import csstl_pkg::*;

	logic in_beat;
	assign in_beat = byte_valid && byte_ready && byte_data.end_of_input;

	`CSSTL_ASSERT_NXT(a_tok_hold, tok_valid && !tok_ready, tok_valid && $stable(tok_data))
	`CSSTL_ASSERT_IMP(a_eof_last, tok_valid && tok_data.token_kind == K_EOF, tok_data.last_result && tok_data.token_end && !tok_data.has_byte)
	`CSSTL_ASSERT_IMP(a_no_byte, tok_valid && !tok_data.has_byte, tok_data.out_byte == 8'd0 && tok_data.token_end)
	`CSSTL_ASSERT_IMP(a_num_part, tok_valid && tok_data.text_part, tok_data.token_kind == K_NUMBER && tok_data.has_byte && !tok_data.token_end)
	`CSSTL_ASSERT_IMP(a_kind_rng, tok_valid || in_beat, !tok_valid || tok_data.token_kind <= K_EOF)

endmodule

bind css_token_stream_lexer_unit csstl_checker u_chk (.*);
`default_nettype wire

>>> dv/tb_css_token_stream_lexer_unit.sv
// ----------------------------------------------------------------------------
// tb_css_token_stream_lexer_unit
// Self-checking bench for the CSS token lexer.
// The bench feeds a short table of hand-picked stylesheet bytes, then random
// stylesheets built from token-shaped fragments and noise. A token predictor
// runs on every accepted beat, and each output beat is compared field by
// field with the oldest expected token beat. Both sides stall at random, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_css_token_stream_lexer_unit;
	import csstl_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 64;
	localparam int N_RANDOM     = 370;
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		in_item_t  it;
		int        nexp;
		out_item_t exp_tok[3];
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_ready;
	in_item_t  byte_data;
	logic      tok_valid;
	logic      tok_ready;
	out_item_t tok_data;

	css_token_stream_lexer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_data   (tok_data)
	);

	stim_row_t stim_q[$];
	out_item_t tok_exp_q[$];
	int        n_fail;
	int        n_accepted;
	int        cycle_cnt;

	// predictor state
	logic [7:0]  la_win[3];
	int          la_fill;
	mode_t       lx_mode;
	mode_t       lx_resume;
	logic [23:0] esc_code;
	int          hex_n;
	logic [7:0]  quote_ch;
	logic [7:0]  hold_buf[3];
	int          hold_n;
	logic [4:0]  kind_cur;
	bit          holding;

	logic [7:0] wb[4];
	int         wlen;
	int         wpos;
	res_t       tok_buf[16];
	int         tok_n;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit c_space(int c);
		return c == 32 || c == 9 || c == 10 || c == 13 || c == 12;
	endfunction

	function automatic bit c_digit(int c);
		return c >= 48 && c <= 57;
	endfunction

	function automatic bit c_hexdig(int c);
		return c_digit(c) || (c >= 97 && c <= 102) || (c >= 65 && c <= 70);
	endfunction

	function automatic bit c_namestart(int c);
		return (c >= 97 && c <= 122) || (c >= 65 && c <= 90) || c == 95 || c >= 128;
	endfunction

	function automatic bit c_namechar(int c);
		return c_namestart(c) || c_digit(c) || c == 45;
	endfunction

	function automatic bit c_startsname(int c0, int c1);
		if (c_namestart(c0) || c0 == 92)
			return 1'b1;
		return c0 == 45 && (c_namestart(c1) || c1 == 45 || c1 == 92);
	endfunction

	function automatic int peek(int k);
		int i;
		i = wpos + k;
		return i < wlen ? int'(wb[i]) : -1;
	endfunction

	function automatic void skip(int k);
		wpos += k;
		if (wpos > wlen)
			wpos = wlen;
	endfunction

	function automatic void put_tok(logic [4:0] k, int b, bit h, bit p, bit e);
		if (tok_n >= 16)
			return;
		tok_buf[tok_n].token_kind = k;
		tok_buf[tok_n].out_byte   = b[7:0];
		tok_buf[tok_n].has_byte   = h;
		tok_buf[tok_n].text_part  = p;
		tok_buf[tok_n].token_end  = e;
		tok_n++;
	endfunction

	function automatic void close_as(logic [4:0] k);
		put_tok(k, 0, 1'b0, 1'b0, 1'b1);
		lx_mode = M_IDLE;
	endfunction

	function automatic void release_hold();
		for (int i = 0; i < hold_n && i < 3; i++)
			put_tok(kind_cur, hold_buf[i], 1'b1, 1'b0, 1'b0);
		hold_n = 0;
	endfunction

	function automatic void feed(int b);
		int lo;
		int want;
		if (holding) begin
			lo = (b >= 65 && b <= 90) ? b + 32 : b;
			want = (hold_n == 0) ? "u" : (hold_n == 1) ? "r" : "l";
			if (hold_n < 3 && lo == want) begin
				hold_buf[hold_n] = b[7:0];
				hold_n++;
				return;
			end
			release_hold();
			holding = 1'b0;
		end
		put_tok(kind_cur, b, 1'b1, 1'b0, 1'b0);
	endfunction

	function automatic void put_cp(logic [23:0] cp);
		if (cp == 0 || (cp >= 24'hD800 && cp <= 24'hDFFF) || cp > 24'h10FFFF) begin
			feed(8'hEF);
			feed(8'hBF);
			feed(8'hBD);
		end else if (cp <= 24'h7F) begin
			feed(cp[7:0]);
		end else if (cp <= 24'h7FF) begin
			feed({3'b110, cp[10:6]});
			feed({2'b10, cp[5:0]});
		end else if (cp <= 24'hFFFF) begin
			feed({4'b1110, cp[15:12]});
			feed({2'b10, cp[11:6]});
			feed({2'b10, cp[5:0]});
		end else begin
			feed({5'b11110, cp[20:18]});
			feed({2'b10, cp[17:12]});
			feed({2'b10, cp[11:6]});
			feed({2'b10, cp[5:0]});
		end
	endfunction

	function automatic void esc_start();
		int c1;
		c1 = peek(1);
		if (c1 < 0) begin
			skip(1);
			put_cp(24'd0);
		end else if (c_hexdig(c1)) begin
			skip(1);
			esc_code = 0;
			hex_n = 0;
			lx_resume = lx_mode;
			lx_mode = M_HEX;
		end else begin
			skip(2);
			feed(c1);
		end
	endfunction

	function automatic void name_open(logic [4:0] k, bit h);
		kind_cur = k;
		holding = h;
		hold_n = 0;
		lx_mode = M_NAME;
	endfunction

	function automatic void lex_idle();
		int c0, c1, c2, c3;
		bit sgn;
		logic [4:0] k;
		c0 = peek(0);
		c1 = peek(1);
		c2 = peek(2);
		c3 = peek(3);
		sgn = (c0 == "+" || c0 == "-");
		if (c0 == "/" && c1 == "*") begin
			skip(2);
			lx_mode = M_COMMENT;
		end else if (c_space(c0)) begin
			skip(1);
			lx_mode = M_WS;
		end else if (c0 == "\"" || c0 == "'") begin
			skip(1);
			quote_ch = c0[7:0];
			kind_cur = K_STRING;
			holding = 1'b0;
			lx_mode = M_STRING;
		end else if (c0 == "#" || c0 == "@") begin
			k = (c0 == "#") ? K_HASH : K_AT;
			skip(1);
			if (c_namestart(c1) || c1 == "\\")
				name_open(k, 1'b0);
			else
				put_tok(K_DELIM, c0, 1'b1, 1'b0, 1'b1);
		end else if (c_digit(c0) || (c0 == "." && c_digit(c1)) || (sgn && c_digit(c1)) ||
				(sgn && c1 == "." && c_digit(c2))) begin
			if (sgn) begin
				skip(1);
				put_tok(K_NUMBER, c0, 1'b1, 1'b1, 1'b0);
			end
			lx_mode = M_INT;
		end else if (c0 == "<" && c1 == "!" && c2 == "-" && c3 == "-") begin
			skip(4);
			put_tok(K_WS, " ", 1'b1, 1'b0, 1'b1);
		end else if (c0 == "-" && c1 == "-" && c2 == ">") begin
			skip(3);
			put_tok(K_WS, " ", 1'b1, 1'b0, 1'b1);
		end else if (c_startsname(c0, c1) && !(c0 == "\\" && c1 < 0)) begin
			name_open(K_IDENT, 1'b1);
		end else begin
			skip(1);
			case (c0)
				":":     k = K_COLON;
				";":     k = K_SEMI;
				",":     k = K_COMMA;
				"{":     k = K_LBRACE;
				"}":     k = K_RBRACE;
				"(":     k = K_LPAREN;
				")":     k = K_RPAREN;
				"[":     k = K_LBRACKET;
				"]":     k = K_RBRACKET;
				default: k = K_DELIM;
			endcase
			put_tok(k, c0, 1'b1, 1'b0, 1'b1);
		end
	endfunction

	function automatic void lex_name(int c0, int c1);
		if (c0 == "\\" && c1 >= 0) begin
			esc_start();
		end else if (c_namechar(c0)) begin
			skip(1);
			feed(c0);
		end else if (kind_cur != K_IDENT) begin
			close_as(kind_cur);
		end else if (c0 == "(") begin
			skip(1);
			if (holding && hold_n == 3) begin
				hold_n = 0;
				holding = 1'b0;
				kind_cur = K_URL;
				lx_mode = M_URL_LEAD;
			end else begin
				release_hold();
				close_as(K_FUNC);
			end
		end else begin
			release_hold();
			close_as(K_IDENT);
		end
	endfunction

	function automatic void lex_string(int c0, int c1, int c2);
		if (c0 < 0) begin
			close_as(K_STRING);
		end else if (c0 == quote_ch) begin
			skip(1);
			close_as(K_STRING);
		end else if (c0 == 10 || c0 == 13 || c0 == 12) begin
			close_as(K_STRING);
		end else if (c0 == "\\") begin
			if (c1 < 0)
				skip(1);
			else if (c1 == 10 || c1 == 12)
				skip(2);
			else if (c1 == 13)
				skip(c2 == 10 ? 3 : 2);
			else
				esc_start();
		end else begin
			skip(1);
			feed(c0);
		end
	endfunction

	function automatic void lex_one();
		int c0, c1, c2;
		logic [3:0] v;
		c0 = peek(0);
		c1 = peek(1);
		c2 = peek(2);
		case (lx_mode)
			M_COMMENT: begin
				if (c0 < 0)
					lx_mode = M_IDLE;
				else if (c0 == "*" && c1 == "/") begin
					skip(2);
					lx_mode = M_IDLE;
				end else
					skip(1);
			end
			M_WS: begin
				if (c_space(c0))
					skip(1);
				else begin
					put_tok(K_WS, " ", 1'b1, 1'b0, 1'b1);
					lx_mode = M_IDLE;
				end
			end
			M_STRING: lex_string(c0, c1, c2);
			M_NAME: lex_name(c0, c1);
			M_INT, M_FRAC: begin
				if (c_digit(c0)) begin
					skip(1);
					put_tok(K_NUMBER, c0, 1'b1, 1'b1, 1'b0);
				end else if (lx_mode == M_INT && c0 == "." && c_digit(c1)) begin
					skip(1);
					put_tok(K_NUMBER, ".", 1'b1, 1'b1, 1'b0);
					lx_mode = M_FRAC;
				end else
					lx_mode = M_EXPMARK;
			end
			M_EXPMARK: begin
				if ((c0 == "e" || c0 == "E") && (c_digit(c1) || c1 == "+" || c1 == "-")) begin
					skip(1);
					put_tok(K_NUMBER, c0, 1'b1, 1'b1, 1'b0);
					lx_mode = M_EXPSIGN;
				end else
					lx_mode = M_SUFFIX;
			end
			M_EXPSIGN: begin
				if (c0 == "+" || c0 == "-") begin
					skip(1);
					put_tok(K_NUMBER, c0, 1'b1, 1'b1, 1'b0);
				end
				lx_mode = M_EXP;
			end
			M_EXP: begin
				if (c_digit(c0)) begin
					skip(1);
					put_tok(K_NUMBER, c0, 1'b1, 1'b1, 1'b0);
				end else
					lx_mode = M_SUFFIX;
			end
			M_SUFFIX: begin
				if (c0 == "%") begin
					skip(1);
					put_tok(K_PERCENT, "%", 1'b1, 1'b0, 1'b1);
					lx_mode = M_IDLE;
				end else if (c_startsname(c0, c1))
					name_open(K_DIM, 1'b0);
				else
					close_as(K_NUMBER);
			end
			M_URL_LEAD: begin
				if (c_space(c0))
					skip(1);
				else if (c0 == "\"" || c0 == "'") begin
					skip(1);
					quote_ch = c0[7:0];
					lx_mode = M_URL_QUOTED;
				end else
					lx_mode = M_URL_RAW;
			end
			M_URL_QUOTED: begin
				if (c0 < 0)
					lx_mode = M_URL_TAIL;
				else if (c0 == quote_ch) begin
					skip(1);
					lx_mode = M_URL_TAIL;
				end else if (c0 == "\\")
					esc_start();
				else begin
					skip(1);
					feed(c0);
				end
			end
			M_URL_RAW: begin
				if (c0 < 0 || c0 == "\"" || c0 == "'")
					close_as(K_URL);
				else if (c0 == ")") begin
					skip(1);
					close_as(K_URL);
				end else if (c_space(c0))
					lx_mode = M_URL_TAIL;
				else if (c0 == "\\")
					esc_start();
				else begin
					skip(1);
					feed(c0);
				end
			end
			M_URL_TAIL: begin
				if (c_space(c0))
					skip(1);
				else begin
					if (c0 == ")")
						skip(1);
					close_as(K_URL);
				end
			end
			M_HEX: begin
				if (hex_n < 6 && c_hexdig(c0)) begin
					v = c_digit(c0) ? 4'(c0 - 48) : 4'((c0 | 32) - 97 + 10);
					esc_code = {esc_code[19:0], v};
					hex_n++;
					skip(1);
				end else begin
					if (c_space(c0))
						skip(1);
					lx_mode = lx_resume;
					put_cp(esc_code);
					esc_code = 0;
					hex_n = 0;
				end
			end
			default: begin
				if (c0 >= 0)
					lex_idle();
				else
					lx_mode = M_IDLE;
			end
		endcase
	endfunction

	function automatic void lexer_clear();
		la_fill = 0;
		lx_mode = M_IDLE;
		lx_resume = M_IDLE;
		esc_code = 0;
		hex_n = 0;
		quote_ch = 0;
		hold_n = 0;
		kind_cur = 0;
		holding = 1'b0;
		for (int i = 0; i < 3; i++) begin
			la_win[i] = 0;
			hold_buf[i] = 0;
		end
	endfunction

	function automatic void lex_beat(in_item_t it);
		for (int i = 0; i < la_fill; i++)
			wb[i] = la_win[i];
		wb[la_fill] = it.in_byte;
		wlen = la_fill + 1;
		wpos = 0;
		tok_n = 0;
		if (!it.end_of_input) begin
			for (int g = 0; g < 256 && wlen - wpos > 3; g++)
				lex_one();
			la_fill = wlen - wpos;
			for (int i = 0; i < la_fill; i++)
				la_win[i] = wb[wpos + i];
		end else begin
			for (int g = 0; g < 256; g++) begin
				if (lx_mode == M_IDLE && peek(0) < 0)
					break;
				lex_one();
			end
			put_tok(K_EOF, 0, 1'b0, 1'b0, 1'b1);
			lexer_clear();
		end
	endfunction

	// stimulus construction
	function automatic out_item_t mk_tok(logic [4:0] k, logic [7:0] b, bit h, bit e, bit l);
		out_item_t t;
		t.token_kind  = k;
		t.out_byte    = b;
		t.has_byte    = h;
		t.text_part   = 1'b0;
		t.token_end   = e;
		t.last_result = l;
		return t;
	endfunction

	function automatic void add_byte(logic [7:0] b, bit eoi);
		stim_row_t r;
		r.it.in_byte = b;
		r.it.end_of_input = eoi;
		r.nexp = 0;
		stim_q.push_back(r);
	endfunction

	function automatic void add_text(string s, bit eoi);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], eoi && i == s.len() - 1);
	endfunction

	function automatic void add_typed(logic [7:0] b, out_item_t t0, out_item_t t1,
			out_item_t t2, int n);
		stim_row_t r;
		r.it.in_byte = b;
		r.it.end_of_input = 1'b1;
		r.nexp = n;
		r.exp_tok[0] = t0;
		r.exp_tok[1] = t1;
		r.exp_tok[2] = t2;
		stim_q.push_back(r);
	endfunction

	function automatic byte rand_letter();
		byte b;
		b = byte'($urandom_range(97, 122));
		if ($urandom_range(0, 3) == 0)
			b = b - 32;
		return b;
	endfunction

	function automatic string rand_hex();
		string s;
		int n;
		string hd;
		hd = "0123456789abcdefABCDEF";
		case ($urandom_range(0, 5))
			0: s = "d800";
			1: s = "110000";
			2: s = "0";
			default: begin
				s = "";
				n = $urandom_range(1, 7);
				for (int i = 0; i < n; i++)
					s = {s, string'(hd[$urandom_range(0, 21)])};
			end
		endcase
		if ($urandom_range(0, 1))
			s = {s, " "};
		return s;
	endfunction

	function automatic string rand_name();
		string s;
		int n;
		s = "";
		case ($urandom_range(0, 5))
			0: s = "url";
			1: s = "URL";
			2: s = "uRl";
			default: ;
		endcase
		n = $urandom_range(s.len() == 0 ? 1 : 0, 4);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0: s = {s, "-"};
				1: s = {s, string'(byte'($urandom_range(48, 57)))};
				2: s = {s, "\\", rand_hex()};
				3: s = {s, string'(byte'($urandom_range(128, 255)))};
				default: s = {s, string'(rand_letter())};
			endcase
		end
		return s;
	endfunction

	function automatic string rand_fragment();
		string s;
		string q;
		int n;
		string pun;
		pun = ":;,{}()[]";
		s = "";
		case ($urandom_range(0, 11))
			0: begin
				s = rand_name();
				if ($urandom_range(0, 2) == 0)
					s = {s, "("};
			end
			1: begin
				if ($urandom_range(0, 3) == 0)
					s = ($urandom_range(0, 1)) ? "-" : "+";
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++)
					s = {s, string'(byte'($urandom_range(48, 57)))};
				if (n == 0 || $urandom_range(0, 2) == 0)
					s = {s, ".", string'(byte'($urandom_range(48, 57)))};
				if ($urandom_range(0, 3) == 0)
					s = {s, ($urandom_range(0, 1)) ? "e" : "E",
						($urandom_range(0, 1)) ? "-" : "", "1"};
				case ($urandom_range(0, 4))
					0: s = {s, "%"};
					1: s = {s, "px"};
					2: s = {s, "e"};
					3: s = {s, rand_name()};
					default: ;
				endcase
			end
			2: begin
				q = ($urandom_range(0, 1)) ? "\"" : "'";
				s = q;
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(0, 7))
						0: s = {s, "\\", rand_hex()};
						1: s = {s, "\\\n"};
						2: s = {s, "\\\r\n"};
						3: s = {s, "\\\""};
						4: s = {s, "\n"};
						default: s = {s, string'(byte'($urandom_range(32, 126)))};
					endcase
				end
				if ($urandom_range(0, 4) != 0)
					s = {s, q};
			end
			3: begin
				s = ($urandom_range(0, 1)) ? "url(" : "Url( ";
				q = "";
				case ($urandom_range(0, 2))
					0: q = "\"";
					1: q = "'";
					default: ;
				endcase
				s = {s, q, rand_name()};
				if ($urandom_range(0, 2) == 0)
					s = {s, "\\", rand_hex()};
				s = {s, q, ($urandom_range(0, 1)) ? " )" : ")"};
			end
			4: begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					s = {s, string'(pun[$urandom_range(0, 1)] == ":" ? " \t\n\r\f" : " ")};
				s = {s, ($urandom_range(0, 1)) ? "\t" : "\f"};
			end
			5: s = {"/*", rand_name(), ($urandom_range(0, 3) == 0) ? "" : "*/"};
			6: s = string'(pun[$urandom_range(0, 8)]);
			7: s = {($urandom_range(0, 1)) ? "#" : "@", rand_name()};
			8: s = ($urandom_range(0, 1)) ? "<!--" : "-->";
			9: s = {"\\", rand_hex()};
			default: s = string'(byte'($urandom_range(0, 255)));
		endcase
		return s;
	endfunction

	function automatic void build_stimulus();
		string s;
		int n_frag;
		add_typed(";", mk_tok(K_SEMI, ";", 1'b1, 1'b1, 1'b0),
			mk_tok(K_EOF, 8'h00, 1'b0, 1'b1, 1'b1), mk_tok(K_EOF, 8'h00, 1'b0, 1'b1, 1'b1), 2);
		add_typed("\\", mk_tok(K_DELIM, "\\", 1'b1, 1'b1, 1'b0),
			mk_tok(K_EOF, 8'h00, 1'b0, 1'b1, 1'b1), mk_tok(K_EOF, 8'h00, 1'b0, 1'b1, 1'b1), 2);
		add_typed(8'hFF, mk_tok(K_IDENT, 8'hFF, 1'b1, 1'b0, 1'b0),
			mk_tok(K_IDENT, 8'h00, 1'b0, 1'b1, 1'b0), mk_tok(K_EOF, 8'h00, 1'b0, 1'b1, 1'b1), 3);
		add_typed(8'h00, mk_tok(K_DELIM, 8'h00, 1'b1, 1'b1, 1'b0),
			mk_tok(K_EOF, 8'h00, 1'b0, 1'b1, 1'b1), mk_tok(K_EOF, 8'h00, 1'b0, 1'b1, 1'b1), 2);
		add_text("/**/uRl( 'a\\110000 \\d800 ' )", 1'b1);
		add_text("-.5e+3px 7% \"x\\\ny\n", 1'b0);
		add_text("<!---->#a@b f(\\41 :;,{}()[]", 1'b1);
		while (stim_q.size() < N_RANDOM) begin
			s = "";
			n_frag = $urandom_range(2, 9);
			for (int i = 0; i < n_frag; i++)
				s = {s, rand_fragment()};
			add_text(s, 1'b1);
		end
	endfunction

	function automatic int phase_of();
		return (n_accepted < N_RANDOM / 3) ? 0 : (n_accepted < 2 * N_RANDOM / 3) ? 1 : 2;
	endfunction

	// sender
	initial begin
		stim_row_t r;
		int sidle;
		n_fail = 0;
		n_accepted = 0;
		lexer_clear();
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		build_stimulus();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (stim_q.size() > 0) begin
			r = stim_q.pop_front();
			sidle = (phase_of() == 0) ? 15 : (phase_of() == 1) ? 75 : 0;
			if ($urandom_range(0, 99) < sidle) begin
				byte_valid <= 1'b0;
				do
					@(posedge clk);
				while ($urandom_range(0, 99) < sidle);
			end
			byte_valid <= 1'b1;
			byte_data <= r.it;
			@(posedge clk);
			while (!byte_ready)
				@(posedge clk);
			lex_beat(r.it);
			if (r.nexp > 0) begin
				for (int i = 0; i < r.nexp; i++)
					tok_exp_q.push_back(r.exp_tok[i]);
			end else begin
				for (int i = 0; i < tok_n; i++)
					tok_exp_q.push_back({tok_buf[i], i == tok_n - 1});
			end
			n_accepted++;
		end
		byte_valid <= 1'b0;
		while (tok_exp_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0 && tok_exp_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// receiver
	initial begin
		int ridle;
		bit held;
		held = 1'b0;
		tok_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && n_accepted > N_RANDOM / 2) begin
				held = 1'b1;
				tok_ready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++)
					@(posedge clk);
			end
			ridle = (phase_of() == 0) ? 75 : (phase_of() == 1) ? 15 : 0;
			tok_ready <= ($urandom_range(0, 99) >= ridle);
		end
	end

	// token beat checker
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && tok_valid && tok_ready) begin
			if (tok_exp_q.size() == 0) begin
				$error("unexpected token beat kind=%0d byte=%02h", tok_data.token_kind,
					tok_data.out_byte);
				n_fail++;
			end else begin
				e = tok_exp_q.pop_front();
				if (tok_data.token_kind !== e.token_kind) begin
					$error("token_kind exp=%0d got=%0d", e.token_kind, tok_data.token_kind);
					n_fail++;
				end
				if (tok_data.out_byte !== e.out_byte) begin
					$error("out_byte exp=%02h got=%02h", e.out_byte, tok_data.out_byte);
					n_fail++;
				end
				if (tok_data.has_byte !== e.has_byte) begin
					$error("has_byte exp=%0b got=%0b", e.has_byte, tok_data.has_byte);
					n_fail++;
				end
				if (tok_data.text_part !== e.text_part) begin
					$error("text_part exp=%0b got=%0b", e.text_part, tok_data.text_part);
					n_fail++;
				end
				if (tok_data.token_end !== e.token_end) begin
					$error("token_end exp=%0b got=%0b", e.token_end, tok_data.token_end);
					n_fail++;
				end
				if (tok_data.last_result !== e.last_result) begin
					$error("last_result exp=%0b got=%0b", e.last_result, tok_data.last_result);
					n_fail++;
				end
			end
		end
	end

	// watchdog
	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt >= LIMIT_CYCLES) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule

>>> filelist.f
+incdir+src
src/csstl_pkg.sv
src/csstl_front.sv
src/csstl_engine.sv
src/csstl_outstage.sv
src/css_token_stream_lexer_unit.sv
src/csstl_checker.sv
dv/tb_css_token_stream_lexer_unit.sv
